FILE: src/lcal_pkg.sv
// shared types, constants and codes for the lowest common ancestor lifting engine
// no dependencies; every other file takes names from here by scope
package lcal_pkg;

   // table geometry
   localparam int MAX_NODES   = 1024;
   localparam int LIFT_LEVELS = 10;

   // field and index widths
   localparam int FIELD_W = 10;
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int LEVEL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int JMP_AW  = NODE_W + LEVEL_W;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [1:0]         func_type;

   localparam level_type TOP_LEVEL = level_type'(LIFT_LEVELS - 1);
   localparam node_type  NODE_ONE  = node_type'(1);

   // function codes on the request channel
   localparam func_type FUNC_LOAD  = 2'd0;
   localparam func_type FUNC_BUILD = 2'd1;
   localparam func_type FUNC_QUERY = 2'd2;

   // memory commands from the engine
   typedef struct packed {
      logic      jmp_rd_en;
      node_type  jmp_rd_node_a;
      level_type jmp_rd_level_a;
      node_type  jmp_rd_node_b;
      level_type jmp_rd_level_b;
      logic      jmp_wr_en;
      node_type  jmp_wr_node;
      level_type jmp_wr_level;
      node_type  jmp_wr_data;
      logic      dep_rd_en;
      node_type  dep_rd_node_a;
      node_type  dep_rd_node_b;
      logic      dep_wr_en;
      node_type  dep_wr_node;
      field_type dep_wr_data;
   } mem_cmd_type;

   // registered read data back to the engine
   typedef struct packed {
      node_type  jmp_a;
      node_type  jmp_b;
      field_type dep_a;
      field_type dep_b;
   } mem_data_type;

   // finished result offered to the output register
   typedef struct packed {
      logic      valid;
      field_type ancestor;
   } res_type;

endpackage

FILE: src/lcal_if.sv
// valid/ready channel interfaces for request, response and register write
// depends on lcal_pkg for the payload types
interface lcal_req_if;
   logic                valid;
   logic                ready;
   lcal_pkg::func_type  func;
   lcal_pkg::field_type first_node;
   lcal_pkg::field_type second_node;
   lcal_pkg::field_type node_depth;

   modport source (output valid, func, first_node, second_node, node_depth, input ready);
   modport sink   (input valid, func, first_node, second_node, node_depth, output ready);
endinterface

interface lcal_rsp_if;
   logic                valid;
   logic                ready;
   lcal_pkg::field_type ancestor;

   modport source (output valid, ancestor, input ready);
   modport sink   (input valid, ancestor, output ready);
endinterface

interface lcal_csr_if;
   logic                valid;
   logic                ready;
   lcal_pkg::field_type node_count;

   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

FILE: src/lowest_common_ancestor_lifting.sv
// top level of the binary lifting common ancestor engine
// depends on lcal_pkg, lcal_if, lcal_mem and lcal_engine
//
//   channel  | direction | payload                                   | transfer
//   ---------+-----------+-------------------------------------------+------------------
//   req_ch   | in        | func, first_node, second_node, node_depth | valid & ready
//   rsp_ch   | out       | ancestor (queries only)                   | valid & ready
//   csr_ch   | in        | node_count                                | valid & ready
//
// one item at a time: no new request is taken until the current load, build or query
// is done; a query skips the joint climb when the lift lands on the other node.
// each step waits on the registered reads of the ancestor table and the depth store.
// reset clears the sequencer and sets node_count to 1; the tables need no clearing pass.
// a finished result waits in the output register while the next item is taken;
// a query finishing while that register is still full holds the engine until it drains.
module lowest_common_ancestor_lifting (
   input logic        clock,
   input logic        reset,
   lcal_req_if.sink   req_ch,
   lcal_rsp_if.source rsp_ch,
   lcal_csr_if.sink   csr_ch
);

   lcal_pkg::field_type    node_count_ff, node_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lcal_pkg::field_type    rsp_anc_ff, rsp_anc_in;
   lcal_pkg::res_type      res;
   lcal_pkg::mem_cmd_type  mem_cmd;
   lcal_pkg::mem_data_type mem_data;
   logic                   res_take;

   // register write port, always ready
   assign csr_ch.ready  = 1'b1;
   assign node_count_in = csr_ch.valid ? csr_ch.node_count : node_count_ff;

   // output register
   assign res_take     = res.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = res_take ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_anc_in   = res_take ? res.ancestor : rsp_anc_ff;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ancestor = rsp_anc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= lcal_pkg::field_type'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_anc_ff <= rsp_anc_in;
   end

   lcal_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .node_count (node_count_ff),
      .res_take   (res_take),
      .res        (res),
      .mem_cmd    (mem_cmd),
      .mem_data   (mem_data)
   );

   lcal_mem u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .data  (mem_data)
   );

endmodule

FILE: src/lcal_mem.sv
// ancestor table and depth store, two registered read ports and one write port each
// depends on lcal_pkg; node zero reads back as zero (sentinel row, never written)
module lcal_mem (
   input  logic                   clock,
   input  lcal_pkg::mem_cmd_type  cmd,
   output lcal_pkg::mem_data_type data
);

   localparam int JMP_DEPTH = 2 ** lcal_pkg::JMP_AW;

   lcal_pkg::node_type  jmp_mem [JMP_DEPTH];
   lcal_pkg::field_type dep_mem [lcal_pkg::MAX_NODES];

   lcal_pkg::node_type  jmp_a_ff, jmp_b_ff;
   lcal_pkg::field_type dep_a_ff, dep_b_ff;
   logic                jmp_a_zero_ff, jmp_b_zero_ff;
   logic                dep_a_zero_ff, dep_b_zero_ff;
   logic                jmp_a_fwd;

   // port a reads the entry being written in the same cycle
   assign jmp_a_fwd = cmd.jmp_wr_en &&
                      ({cmd.jmp_wr_node, cmd.jmp_wr_level} ==
                       {cmd.jmp_rd_node_a, cmd.jmp_rd_level_a});

   // ancestor table, addressed by node then level
   always_ff @(posedge clock) begin
      if (cmd.jmp_wr_en) begin
         jmp_mem[{cmd.jmp_wr_node, cmd.jmp_wr_level}] <= cmd.jmp_wr_data;
      end
      if (cmd.jmp_rd_en) begin
         if (jmp_a_fwd) begin
            jmp_a_ff <= cmd.jmp_wr_data;
         end else begin
            jmp_a_ff <= jmp_mem[{cmd.jmp_rd_node_a, cmd.jmp_rd_level_a}];
         end
         jmp_b_ff      <= jmp_mem[{cmd.jmp_rd_node_b, cmd.jmp_rd_level_b}];
         jmp_a_zero_ff <= (cmd.jmp_rd_node_a == '0);
         jmp_b_zero_ff <= (cmd.jmp_rd_node_b == '0);
      end
   end

   // depth store
   always_ff @(posedge clock) begin
      if (cmd.dep_wr_en) begin
         dep_mem[cmd.dep_wr_node] <= cmd.dep_wr_data;
      end
      if (cmd.dep_rd_en) begin
         dep_a_ff      <= dep_mem[cmd.dep_rd_node_a];
         dep_b_ff      <= dep_mem[cmd.dep_rd_node_b];
         dep_a_zero_ff <= (cmd.dep_rd_node_a == '0);
         dep_b_zero_ff <= (cmd.dep_rd_node_b == '0);
      end
   end

   // sentinel node reads as zero on every level
   assign data.jmp_a = jmp_a_zero_ff ? '0 : jmp_a_ff;
   assign data.jmp_b = jmp_b_zero_ff ? '0 : jmp_b_ff;
   assign data.dep_a = dep_a_zero_ff ? '0 : dep_a_ff;
   assign data.dep_b = dep_b_zero_ff ? '0 : dep_b_ff;

endmodule

FILE: src/lcal_engine.sv
// sequencer for load, table build and common ancestor query
// depends on lcal_pkg and lcal_req_if; drives the lcal_mem command struct
module lcal_engine (
   input  logic                   clock,
   input  logic                   reset,
   lcal_req_if.sink               req_ch,
   input  lcal_pkg::field_type    node_count,
   input  logic                   res_take,
   output lcal_pkg::res_type      res,
   output lcal_pkg::mem_cmd_type  mem_cmd,
   input  lcal_pkg::mem_data_type mem_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_B_HOP  = 4'd1;
   localparam logic [3:0] ST_B_WR   = 4'd2;
   localparam logic [3:0] ST_Q_DEP  = 4'd3;
   localparam logic [3:0] ST_Q_LIFT = 4'd4;
   localparam logic [3:0] ST_Q_LJMP = 4'd5;
   localparam logic [3:0] ST_Q_LDEP = 4'd6;
   localparam logic [3:0] ST_Q_EQ   = 4'd7;
   localparam logic [3:0] ST_Q_CMP  = 4'd8;
   localparam logic [3:0] ST_Q_FIN  = 4'd9;
   localparam logic [3:0] ST_Q_OUT  = 4'd10;

   logic [3:0]          state_ff, state_in;
   lcal_pkg::level_type lvl_ff, lvl_in;
   lcal_pkg::node_type  a_ff, a_in;
   lcal_pkg::node_type  b_ff, b_in;
   lcal_pkg::node_type  last_ff, last_in;
   lcal_pkg::node_type  anc_ff, anc_in;
   lcal_pkg::field_type da_ff, da_in;
   lcal_pkg::field_type db_ff, db_in;

   lcal_pkg::node_type  req_n1, req_n2, last_w, a_nx, b_nx;
   lcal_pkg::field_type gap;
   logic                lift_hit;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign res.valid    = (state_ff == ST_Q_OUT);
   assign res.ancestor = lcal_pkg::field_type'(anc_ff);

   // node numbers wrap to the table size
   assign req_n1 = req_ch.first_node[lcal_pkg::NODE_W-1:0];
   assign req_n2 = req_ch.second_node[lcal_pkg::NODE_W-1:0];

   // build range clamped to the highest table row
   assign last_w = (32'(node_count) > 32'(lcal_pkg::MAX_NODES - 1))
                   ? lcal_pkg::node_type'(lcal_pkg::MAX_NODES - 1)
                   : lcal_pkg::node_type'(node_count);

   // lift test: gap at least two to the current level
   assign gap      = db_ff - da_ff;
   assign lift_hit = (db_ff >= da_ff) && ((gap >> lvl_ff) != '0);

   // pairwise jump when the two ancestors differ
   assign a_nx = (mem_data.jmp_a != mem_data.jmp_b) ? mem_data.jmp_a : a_ff;
   assign b_nx = (mem_data.jmp_a != mem_data.jmp_b) ? mem_data.jmp_b : b_ff;

   // next state and memory commands
   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      last_in  = last_ff;
      anc_in   = anc_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      mem_cmd  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func == lcal_pkg::FUNC_LOAD) begin
                  if (req_n1 != '0) begin
                     mem_cmd.jmp_wr_en    = 1'b1;
                     mem_cmd.jmp_wr_node  = req_n1;
                     mem_cmd.jmp_wr_level = '0;
                     mem_cmd.jmp_wr_data  = req_n2;
                     mem_cmd.dep_wr_en    = 1'b1;
                     mem_cmd.dep_wr_node  = req_n1;
                     mem_cmd.dep_wr_data  = req_ch.node_depth;
                  end
               end else if (req_ch.func == lcal_pkg::FUNC_BUILD) begin
                  if (last_w != '0 && lcal_pkg::LIFT_LEVELS > 1) begin
                     last_in                = last_w;
                     a_in                   = lcal_pkg::NODE_ONE;
                     lvl_in                 = lcal_pkg::level_type'(1);
                     mem_cmd.jmp_rd_en      = 1'b1;
                     mem_cmd.jmp_rd_node_a  = lcal_pkg::NODE_ONE;
                     mem_cmd.jmp_rd_level_a = '0;
                     state_in               = ST_B_HOP;
                  end
               end else if (req_ch.func == lcal_pkg::FUNC_QUERY) begin
                  a_in                  = req_n1;
                  b_in                  = req_n2;
                  mem_cmd.dep_rd_en     = 1'b1;
                  mem_cmd.dep_rd_node_a = req_n1;
                  mem_cmd.dep_rd_node_b = req_n2;
                  state_in              = ST_Q_DEP;
               end
            end
         end

         // build: second hop through the level below
         ST_B_HOP: begin
            mem_cmd.jmp_rd_en      = 1'b1;
            mem_cmd.jmp_rd_node_a  = mem_data.jmp_a;
            mem_cmd.jmp_rd_level_a = lvl_ff - 1'b1;
            state_in               = ST_B_WR;
         end

         // build: write the entry, then start the next node, the next level, or return to idle
         ST_B_WR: begin
            mem_cmd.jmp_wr_en    = 1'b1;
            mem_cmd.jmp_wr_node  = a_ff;
            mem_cmd.jmp_wr_level = lvl_ff;
            mem_cmd.jmp_wr_data  = mem_data.jmp_a;
            if (a_ff == last_ff) begin
               if (lvl_ff == lcal_pkg::TOP_LEVEL) begin
                  state_in = ST_IDLE;
               end else begin
                  a_in                   = lcal_pkg::NODE_ONE;
                  lvl_in                 = lvl_ff + 1'b1;
                  mem_cmd.jmp_rd_en      = 1'b1;
                  mem_cmd.jmp_rd_node_a  = lcal_pkg::NODE_ONE;
                  mem_cmd.jmp_rd_level_a = lvl_ff;
                  state_in               = ST_B_HOP;
               end
            end else begin
               a_in                   = a_ff + 1'b1;
               mem_cmd.jmp_rd_en      = 1'b1;
               mem_cmd.jmp_rd_node_a  = a_ff + 1'b1;
               mem_cmd.jmp_rd_level_a = lvl_ff - 1'b1;
               state_in               = ST_B_HOP;
            end
         end

         // query: order the pair so b is the deeper node
         ST_Q_DEP: begin
            if (mem_data.dep_a > mem_data.dep_b) begin
               a_in  = b_ff;
               b_in  = a_ff;
               da_in = mem_data.dep_b;
               db_in = mem_data.dep_a;
            end else begin
               da_in = mem_data.dep_a;
               db_in = mem_data.dep_b;
            end
            lvl_in   = lcal_pkg::TOP_LEVEL;
            state_in = ST_Q_LIFT;
         end

         // query: raise b one level at a time from the top
         ST_Q_LIFT: begin
            if (lift_hit) begin
               mem_cmd.jmp_rd_en      = 1'b1;
               mem_cmd.jmp_rd_node_b  = b_ff;
               mem_cmd.jmp_rd_level_b = lvl_ff;
               state_in               = ST_Q_LJMP;
            end else if (lvl_ff == '0) begin
               state_in = ST_Q_EQ;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end

         ST_Q_LJMP: begin
            b_in                  = mem_data.jmp_b;
            mem_cmd.dep_rd_en     = 1'b1;
            mem_cmd.dep_rd_node_b = mem_data.jmp_b;
            state_in              = ST_Q_LDEP;
         end

         ST_Q_LDEP: begin
            db_in = mem_data.dep_b;
            if (lvl_ff == '0) begin
               state_in = ST_Q_EQ;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = ST_Q_LIFT;
            end
         end

         // query: same node after lifting ends the search
         ST_Q_EQ: begin
            if (a_ff == b_ff) begin
               anc_in   = a_ff;
               state_in = ST_Q_OUT;
            end else begin
               lvl_in                 = lcal_pkg::TOP_LEVEL;
               mem_cmd.jmp_rd_en      = 1'b1;
               mem_cmd.jmp_rd_node_a  = a_ff;
               mem_cmd.jmp_rd_level_a = lcal_pkg::TOP_LEVEL;
               mem_cmd.jmp_rd_node_b  = b_ff;
               mem_cmd.jmp_rd_level_b = lcal_pkg::TOP_LEVEL;
               state_in               = ST_Q_CMP;
            end
         end

         // query: joint climb while ancestors differ
         ST_Q_CMP: begin
            a_in              = a_nx;
            b_in              = b_nx;
            mem_cmd.jmp_rd_en = 1'b1;
            if (lvl_ff == '0) begin
               mem_cmd.jmp_rd_node_a  = a_nx;
               mem_cmd.jmp_rd_level_a = '0;
               state_in               = ST_Q_FIN;
            end else begin
               lvl_in                 = lvl_ff - 1'b1;
               mem_cmd.jmp_rd_node_a  = a_nx;
               mem_cmd.jmp_rd_level_a = lvl_ff - 1'b1;
               mem_cmd.jmp_rd_node_b  = b_nx;
               mem_cmd.jmp_rd_level_b = lvl_ff - 1'b1;
            end
         end

         ST_Q_FIN: begin
            anc_in   = mem_data.jmp_a;
            state_in = ST_Q_OUT;
         end

         // hand the result to the output register
         ST_Q_OUT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      anc_ff  <= anc_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
   end

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the binary lifting common ancestor engine
// builds random rooted trees, predicts every query answer and checks each response transfer
// depends on lcal_pkg, the lcal_if channel interfaces and lowest_common_ancestor_lifting
module tb_top;

   // the one function code the block ignores
   localparam lcal_pkg::func_type FUNC_UNUSED = 2'd3;

   localparam int STALL_LIMIT     = 100000;
   localparam int RSP_HOLD_CYCLES = 400;

   typedef struct packed {
      lcal_pkg::func_type  func;
      lcal_pkg::field_type first_node;
      lcal_pkg::field_type second_node;
      lcal_pkg::field_type node_depth;
   } lca_request_type;

   logic clock;
   logic reset;

   lcal_req_if req_ch ();
   lcal_rsp_if rsp_ch ();
   lcal_csr_if csr_ch ();

   lowest_common_ancestor_lifting u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted engine state
   lcal_pkg::node_type  lift_table [lcal_pkg::MAX_NODES][lcal_pkg::LIFT_LEVELS];
   lcal_pkg::field_type depth_table [lcal_pkg::MAX_NODES];
   lcal_pkg::field_type count_reg;

   // stimulus and scoreboard
   lca_request_type     pending_requests [$];
   lcal_pkg::field_type expected_ancestors [$];
   int                  gen_parent [lcal_pkg::MAX_NODES];
   int                  gen_depth [lcal_pkg::MAX_NODES];
   int                  tree_items;
   int                  errors;
   int unsigned         sender_idle_pct;
   int unsigned         receiver_idle_pct;
   bit                  pressure_armed;
   bit                  pressure_done;
   int                  hold_left;
   int                  quiet_cycles;

   always #2 clock = ~clock;

   // apply one accepted request to the predicted state, queue any answer
   function automatic void update_tree_model(input lca_request_type item);
      lcal_pkg::node_type a, b, t;
      int                 last, lvl, j, i, gap;
      a = lcal_pkg::node_type'(item.first_node);
      b = lcal_pkg::node_type'(item.second_node);
      case (item.func)
         lcal_pkg::FUNC_LOAD: begin
            // node zero is the sentinel and never changes
            if (a != 0) begin
               lift_table[a][0] = b;
               depth_table[a]   = item.node_depth;
            end
         end
         lcal_pkg::FUNC_BUILD: begin
            last = (int'(count_reg) > lcal_pkg::MAX_NODES - 1) ? lcal_pkg::MAX_NODES - 1
                                                                : int'(count_reg);
            for (lvl = 1; lvl < lcal_pkg::LIFT_LEVELS; lvl++) begin
               for (j = 1; j <= last; j++) begin
                  lift_table[j][lvl] = lift_table[lift_table[j][lvl-1]][lvl-1];
               end
            end
         end
         lcal_pkg::FUNC_QUERY: begin
            if (depth_table[a] > depth_table[b]) begin
               t = a;
               a = b;
               b = t;
            end
            // raise the deeper node to the depth of the other
            for (i = lcal_pkg::LIFT_LEVELS - 1; i >= 0; i--) begin
               gap = int'(depth_table[b]) - int'(depth_table[a]);
               if (gap >= (1 << i)) begin
                  b = lift_table[b][i];
               end
            end
            if (a == b) begin
               expected_ancestors = {expected_ancestors, lcal_pkg::field_type'(a)};
            end else begin
               // climb together while the ancestors still differ
               for (i = lcal_pkg::LIFT_LEVELS - 1; i >= 0; i--) begin
                  if (lift_table[a][i] != lift_table[b][i]) begin
                     a = lift_table[a][i];
                     b = lift_table[b][i];
                  end
               end
               expected_ancestors = {expected_ancestors,
                                     lcal_pkg::field_type'(lift_table[a][0])};
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void push_req(input lcal_pkg::func_type f, input int a, input int b,
                                    input int d);
      lca_request_type item;
      item.func        = f;
      item.first_node  = lcal_pkg::field_type'(a);
      item.second_node = lcal_pkg::field_type'(b);
      item.node_depth  = lcal_pkg::field_type'(d);
      pending_requests = {pending_requests, item};
   endfunction

   function automatic void shuffle_nodes(ref int q[$]);
      int i, j, t;
      for (i = q.size() - 1; i > 0; i--) begin
         j    = $urandom_range(0, i);
         t    = q[i];
         q[i] = q[j];
         q[j] = t;
      end
   endfunction

   // items the block ignores or that touch only nodes outside the live tree
   function automatic void push_noise(input int n);
      case ($urandom_range(0, 2))
         0: push_req(FUNC_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
         1: push_req(lcal_pkg::FUNC_LOAD, 0, $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
         default: begin
            if (n < lcal_pkg::MAX_NODES - 1) begin
               push_req(lcal_pkg::FUNC_LOAD, $urandom_range(n + 1, lcal_pkg::MAX_NODES - 1),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
            end else begin
               push_req(FUNC_UNUSED, 0, 0, $urandom_range(0, 1023));
            end
         end
      endcase
   endfunction

   // wait for every request and response, then for a build to wind down
   task automatic wait_quiet();
      while (pending_requests.size() != 0 || expected_ancestors.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * (lcal_pkg::LIFT_LEVELS - 1) * int'(count_reg) + 64) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_node_count(input int value);
      @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.node_count <= lcal_pkg::field_type'(value);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      count_reg = lcal_pkg::field_type'(value);
      @(negedge clock);
   endtask

   // one tree of n nodes: shape, shuffled loads, build, then queries
   task automatic run_tree_session(input int n, input int bias, input int n_queries);
      int order [$];
      int placed [$];
      int v, p, maxd, offset, k, steps, x, y, j;
      wait_quiet();
      write_node_count(n);
      order = {};
      for (v = 2; v <= n; v++) order = {order, v};
      shuffle_nodes(order);
      placed        = {1};
      gen_parent[1] = 0;
      gen_depth[1]  = 0;
      maxd          = 0;
      for (j = 0; j < order.size(); j++) begin
         v = order[j];
         if ($urandom_range(0, 99) < bias) p = placed[placed.size() - 1];
         else p = placed[$urandom_range(0, placed.size() - 1)];
         gen_parent[v] = p;
         gen_depth[v]  = gen_depth[p] + 1;
         if (gen_depth[v] > maxd) maxd = gen_depth[v];
         placed = {placed, v};
      end
      // depths may all be shifted, the gaps are what matter
      case ($urandom_range(0, 3))
         0: offset = 0;
         1: offset = 1023 - maxd;
         default: offset = $urandom_range(0, 1023 - maxd);
      endcase
      shuffle_nodes(placed);
      for (j = 0; j < placed.size(); j++) begin
         if ($urandom_range(0, 9) == 0) push_noise(n);
         v = placed[j];
         push_req(lcal_pkg::FUNC_LOAD, v, gen_parent[v], gen_depth[v] + offset);
      end
      push_req(lcal_pkg::FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023));
      for (k = 0; k < n_queries; k++) begin
         if ($urandom_range(0, 7) == 0) push_noise(n);
         x = $urandom_range(1, n);
         case ($urandom_range(0, 3))
            0: y = $urandom_range(1, n);
            1: begin
               // ancestor of x, near or far
               y     = x;
               steps = $urandom_range(0, $urandom_range(0, 1) ? 4 : 1023);
               while (steps != 0 && y != 1) begin
                  y = gen_parent[y];
                  steps--;
               end
            end
            2: y = x;
            default: y = 1;
         endcase
         if ($urandom_range(0, 1)) begin
            push_req(lcal_pkg::FUNC_QUERY, x, y, $urandom_range(0, 1023));
         end else begin
            push_req(lcal_pkg::FUNC_QUERY, y, x, $urandom_range(0, 1023));
         end
      end
      tree_items += n + 1 + n_queries;
   endtask

   // request driver, predicts on each accepted transfer
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            update_tree_model(pending_requests.pop_front());
            offer = 1'b0;
         end
         if (!offer && pending_requests.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            offer = 1'b1;
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.func        <= pending_requests[0].func;
            req_ch.first_node  <= pending_requests[0].first_node;
            req_ch.second_node <= pending_requests[0].second_node;
            req_ch.node_depth  <= pending_requests[0].node_depth;
         end
      end
   end

   // response monitor and receiver back-pressure
   always @(posedge clock) begin
      lcal_pkg::field_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_ancestors.size() == 0) begin
               errors++;
               $display("%0t: ancestor %0d arrived with nothing expected", $time,
                        rsp_ch.ancestor);
            end else begin
               want = expected_ancestors.pop_front();
               if (rsp_ch.ancestor !== want) begin
                  errors++;
                  $display("%0t: ancestor mismatch, expected %0d, actual %0d", $time, want,
                           rsp_ch.ancestor);
               end
            end
         end
         // one long hold-off so the engine backs up into the request channel
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (pressure_armed && !pressure_done && rsp_ch.valid) begin
            pressure_done = 1'b1;
            hold_left     = RSP_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int r, c, n, q;
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = lcal_pkg::FUNC_LOAD;
      req_ch.first_node  = '0;
      req_ch.second_node = '0;
      req_ch.node_depth  = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.node_count  = '0;
      for (r = 0; r < lcal_pkg::MAX_NODES; r++) begin
         depth_table[r] = '0;
         for (c = 0; c < lcal_pkg::LIFT_LEVELS; c++) lift_table[r][c] = '0;
      end
      count_reg         = lcal_pkg::field_type'(1);
      tree_items        = 0;
      errors            = 0;
      pressure_armed    = 1'b0;
      pressure_done     = 1'b0;
      hold_left         = 0;
      quiet_cycles      = 0;
      sender_idle_pct   = 20;
      receiver_idle_pct = 78;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // root alone, sentinel load, unused code, far stray node
      push_req(lcal_pkg::FUNC_LOAD, 0, 1023, 1023);
      push_req(FUNC_UNUSED, 1023, 1023, 1023);
      push_req(lcal_pkg::FUNC_LOAD, 1, 0, 0);
      push_req(lcal_pkg::FUNC_LOAD, 1023, 1023, 1023);
      push_req(lcal_pkg::FUNC_BUILD, 0, 0, 0);
      push_req(lcal_pkg::FUNC_QUERY, 1, 1, 0);

      // small tree: chain 1-2-3 with 4 beside 2
      wait_quiet();
      write_node_count(4);
      push_req(lcal_pkg::FUNC_LOAD, 2, 1, 1);
      push_req(lcal_pkg::FUNC_LOAD, 3, 2, 2);
      push_req(lcal_pkg::FUNC_LOAD, 4, 1, 1);
      push_req(lcal_pkg::FUNC_BUILD, 0, 0, 0);
      push_req(lcal_pkg::FUNC_QUERY, 3, 2, 0);
      push_req(lcal_pkg::FUNC_QUERY, 2, 3, 0);
      push_req(lcal_pkg::FUNC_QUERY, 3, 4, 0);
      push_req(lcal_pkg::FUNC_QUERY, 4, 3, 0);
      push_req(lcal_pkg::FUNC_QUERY, 1, 3, 0);
      push_req(lcal_pkg::FUNC_QUERY, 3, 3, 0);

      // empty build leaves the table as it was
      wait_quiet();
      write_node_count(0);
      push_req(lcal_pkg::FUNC_BUILD, 0, 0, 0);
      push_req(lcal_pkg::FUNC_QUERY, 3, 4, 0);

      // random trees, mostly small
      while (tree_items < 150) begin
         if (tree_items >= 75) begin
            sender_idle_pct   = 78;
            receiver_idle_pct = 20;
         end
         case ($urandom_range(0, 9))
            0: n = 1;
            1: n = $urandom_range(100, 300);
            default: n = $urandom_range(2, 40);
         endcase
         run_tree_session(n, $urandom_range(0, 100), $urandom_range(10, 30));
         if ($urandom_range(0, 4) == 0) begin
            wait_quiet();
            write_node_count(0);
            push_req(lcal_pkg::FUNC_BUILD, 0, 0, 0);
            for (q = 0; q < 3; q++) begin
               push_req(lcal_pkg::FUNC_QUERY, $urandom_range(1, n), $urandom_range(1, n),
                        $urandom_range(0, 1023));
            end
            tree_items += 4;
         end
      end

      // large deep tree with no idling and one long receiver stall
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_tree_session(600, 95, 60);
      pressure_armed = 1'b1;

      wait_quiet();
      if (errors == 0 && expected_ancestors.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: lowest_common_ancestor_lifting.f
src/lcal_pkg.sv
src/lcal_if.sv
src/lcal_mem.sv
src/lcal_engine.sv
src/lowest_common_ancestor_lifting.sv
test/tb_top.sv
